>>> rtl/btffa_pkg.sv
// Shared types and constants of the block table first-fit allocator.
package btffa_pkg;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned SIZE_W    = 24;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned BIU_W     = 11;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned ENTRY_W   = 3;

  localparam int unsigned ENT_TAKEN = 0;
  localparam int unsigned ENT_FIRST = 1;
  localparam int unsigned ENT_NEXT  = 2;

  localparam logic [BIU_W-1:0] BIU_RESET = 11'd1024;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NOMEM   = 2'd1,
    STAT_BADADDR = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_ADDRESS  = 1'b0,
    REG_BLOCKS_IN_USE = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_DIV,
    S_FREE_RD,
    S_CHAIN,
    S_DONE
  } state_e;

endpackage

>>> rtl/btffa_if.sv
// Request and response channel interfaces of the allocator.
interface btffa_req_if;
  logic                             valid;
  logic                             ready;
  logic                             op;
  logic [btffa_pkg::SIZE_W-1:0]     size_bytes;
  logic [btffa_pkg::ADDR_W-1:0]     free_address;

  modport source (output valid, output op, output size_bytes, output free_address,
                  input ready);
  modport sink   (input valid, input op, input size_bytes, input free_address,
                  output ready);
endinterface

interface btffa_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [btffa_pkg::ADDR_W-1:0]     alloc_address;
  logic [btffa_pkg::STATUS_W-1:0]   status;

  modport source (output valid, output alloc_address, output status, input ready);
  modport sink   (input valid, input alloc_address, input status, output ready);
endinterface

>>> rtl/btffa_mem.sv
// Block table memory: one write port, one read port, registered read data.
module btffa_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 3
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/btffa_div.sv
// Division by the constant block size through reciprocal multiplication.
module btffa_div #(
  parameter int unsigned DIVISOR = 4096,
  parameter int unsigned DW      = 22
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);

  localparam int unsigned SH = DW + $clog2(DIVISOR);
  localparam int unsigned MW = DW + 1;
  localparam int unsigned PW = DW + MW;
  localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

  logic          done_q;
  logic [DW-1:0] num_q;
  logic [PW-1:0] prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
    end
  end

  assign prod   = PW'(num_q) * PW'(RECIP[MW-1:0]);
  assign done_o = done_q;
  assign quot_o = DW'(prod >> SH);

endmodule

>>> rtl/block_table_first_fit_allocator.sv
// Top level of the block table first-fit heap allocator.
//
//   channel | dir | word                                  | accepted when
//   req_i   | in  | op, size_bytes, free_address          | valid && ready
//   rsp_o   | out | alloc_address, status                 | valid && ready
//   cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i       | cfg_we_i
//
// Allocate: a scan of the table up to the heap limit, then one table write per block
// of the granted run, then the result is handed over.
// Free: the divider forms the block index, then each block of the chain is read and cleared.
// After reset a clearing pass writes every entry; no request is taken.
// One request is in work at a time; a new one is taken while the last result waits.
module block_table_first_fit_allocator #(
  parameter int unsigned MAX_BLOCKS  = 1024,
  parameter int unsigned BLOCK_BYTES = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  btffa_req_if.sink                       req_i,
  btffa_rsp_if.source                     rsp_o,
  input  logic                            cfg_we_i,
  input  logic [btffa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [btffa_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned IDX_W   = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W   = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned LIM_W   = (CNT_W > btffa_pkg::BIU_W) ? CNT_W : btffa_pkg::BIU_W;
  localparam int unsigned RUN_W   = $clog2((1 << btffa_pkg::SIZE_W) + BLOCK_BYTES);
  localparam int unsigned AW      = btffa_pkg::ADDR_W;
  localparam int unsigned EW      = btffa_pkg::ENTRY_W;
  localparam int unsigned BIU_MAX = (1 << btffa_pkg::BIU_W) - 1;
  localparam int unsigned LIM_CAP = (MAX_BLOCKS < BIU_MAX) ? MAX_BLOCKS : BIU_MAX;
  localparam int unsigned OFF_W   = $clog2(LIM_CAP * BLOCK_BYTES);

  localparam logic [RUN_W-1:0] BB_RUN  = RUN_W'(BLOCK_BYTES);
  localparam logic [AW-1:0]    BB_ADDR = AW'(BLOCK_BYTES);

  btffa_pkg::state_e  state_q, state_d;
  btffa_pkg::status_e res_stat_q, res_stat_d, rsp_stat_q, rsp_stat_d;

  logic [AW-1:0]                  base_q;
  logic [btffa_pkg::BIU_W-1:0]    biu_q;
  logic [btffa_pkg::SIZE_W-1:0]   size_q, size_d;
  logic [LIM_W-1:0]               iss_idx_q, iss_idx_d;
  logic [AW-1:0]                  iss_addr_q, iss_addr_d;
  logic                           chk_vld_q, chk_vld_d;
  logic [LIM_W-1:0]               chk_idx_q, chk_idx_d;
  logic [AW-1:0]                  chk_addr_q, chk_addr_d;
  logic [RUN_W-1:0]               run_q, run_d;
  logic [LIM_W-1:0]               first_idx_q, first_idx_d;
  logic [AW-1:0]                  first_addr_q, first_addr_d;
  logic [LIM_W-1:0]               mark_idx_q, mark_idx_d;
  logic [RUN_W-1:0]               mark_bytes_q, mark_bytes_d;
  logic [AW-1:0]                  res_addr_q, res_addr_d;
  logic [IDX_W-1:0]               clr_idx_q, clr_idx_d;
  logic                           rsp_vld_q, rsp_vld_d;
  logic [AW-1:0]                  rsp_addr_q, rsp_addr_d;

  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0]    mem_wdata, mem_rdata;

  logic             div_start, div_done;
  logic [OFF_W-1:0] div_quot;

  logic [LIM_W-1:0] lim;
  logic [AW-1:0]    free_off, heap_bytes;
  logic             req_acc, rsp_free, addr_low, free_bad, req_alloc, size_zero;
  logic [RUN_W-1:0] run_add, mark_add;
  logic             scan_hit, scan_fail, mark_more, chain_more, clr_last;
  logic [LIM_W-1:0] chk_next;

  btffa_mem #(
    .DEPTH (MAX_BLOCKS),
    .WIDTH (EW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  btffa_div #(
    .DIVISOR (BLOCK_BYTES),
    .DW      (OFF_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (free_off[OFF_W-1:0]),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign lim = (LIM_W'(biu_q) > LIM_W'(MAX_BLOCKS)) ? LIM_W'(MAX_BLOCKS) : LIM_W'(biu_q);

  assign req_i.ready = (state_q == btffa_pkg::S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign req_alloc   = (req_i.op == btffa_pkg::OP_ALLOC);
  assign size_zero   = (req_i.size_bytes == '0);
  assign addr_low    = (req_i.free_address < base_q);
  assign free_off    = req_i.free_address - base_q;
  assign heap_bytes  = AW'(lim) * BB_ADDR;
  assign free_bad    = addr_low || (free_off >= heap_bytes);
  assign rsp_free    = !rsp_vld_q || rsp_o.ready;

  assign run_add    = run_q + BB_RUN;
  assign scan_hit   = chk_vld_q && !mem_rdata[btffa_pkg::ENT_TAKEN] &&
                      (run_add >= RUN_W'(size_q));
  assign scan_fail  = !chk_vld_q && (iss_idx_q >= lim);
  assign mark_add   = mark_bytes_q + BB_RUN;
  assign mark_more  = mark_add < RUN_W'(size_q);
  assign chk_next   = chk_idx_q + LIM_W'(1);
  assign chain_more = mem_rdata[btffa_pkg::ENT_NEXT] && (chk_next < lim);
  assign clr_last   = (clr_idx_q == IDX_W'(MAX_BLOCKS - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      btffa_pkg::S_CLEAR: begin
        if (clr_last) state_d = btffa_pkg::S_IDLE;
      end
      btffa_pkg::S_IDLE: begin
        if (req_acc) begin
          if (req_alloc) state_d = size_zero ? btffa_pkg::S_DONE : btffa_pkg::S_SCAN;
          else           state_d = free_bad ? btffa_pkg::S_DONE : btffa_pkg::S_DIV;
        end
      end
      btffa_pkg::S_SCAN: begin
        if (scan_hit)       state_d = btffa_pkg::S_MARK;
        else if (scan_fail) state_d = btffa_pkg::S_DONE;
      end
      btffa_pkg::S_MARK: begin
        if (!mark_more) state_d = btffa_pkg::S_DONE;
      end
      btffa_pkg::S_DIV: begin
        if (div_done) state_d = btffa_pkg::S_FREE_RD;
      end
      btffa_pkg::S_FREE_RD: begin
        state_d = btffa_pkg::S_CHAIN;
      end
      btffa_pkg::S_CHAIN: begin
        if (!chain_more) state_d = btffa_pkg::S_DONE;
      end
      btffa_pkg::S_DONE: begin
        if (rsp_free) state_d = btffa_pkg::S_IDLE;
      end
      default: state_d = btffa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    size_d       = size_q;
    iss_idx_d    = iss_idx_q;
    iss_addr_d   = iss_addr_q;
    chk_vld_d    = chk_vld_q;
    chk_idx_d    = chk_idx_q;
    chk_addr_d   = chk_addr_q;
    run_d        = run_q;
    first_idx_d  = first_idx_q;
    first_addr_d = first_addr_q;
    mark_idx_d   = mark_idx_q;
    mark_bytes_d = mark_bytes_q;
    res_addr_d   = res_addr_q;
    res_stat_d   = res_stat_q;
    clr_idx_d    = clr_idx_q;
    rsp_vld_d    = rsp_vld_q && !rsp_o.ready;
    rsp_addr_d   = rsp_addr_q;
    rsp_stat_d   = rsp_stat_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    div_start    = 1'b0;
    unique case (state_q)
      btffa_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_q;
        clr_idx_d = clr_idx_q + IDX_W'(1);
      end
      btffa_pkg::S_IDLE: begin
        if (req_acc) begin
          size_d     = req_i.size_bytes;
          iss_idx_d  = '0;
          iss_addr_d = base_q;
          chk_vld_d  = 1'b0;
          run_d      = '0;
          res_addr_d = '0;
          res_stat_d = btffa_pkg::STAT_OK;
          if (req_alloc) begin
            if (size_zero) res_stat_d = btffa_pkg::STAT_NOMEM;
          end else if (free_bad) begin
            res_stat_d = btffa_pkg::STAT_BADADDR;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      btffa_pkg::S_SCAN: begin
        if (chk_vld_q) begin
          if (mem_rdata[btffa_pkg::ENT_TAKEN]) begin
            run_d = '0;
          end else begin
            run_d = run_add;
            if (run_q == '0) begin
              first_idx_d  = chk_idx_q;
              first_addr_d = chk_addr_q;
            end
          end
        end
        if (scan_hit) begin
          mark_idx_d   = (run_q == '0) ? chk_idx_q : first_idx_q;
          res_addr_d   = (run_q == '0) ? chk_addr_q : first_addr_q;
          mark_bytes_d = '0;
          res_stat_d   = btffa_pkg::STAT_OK;
        end else if (scan_fail) begin
          res_stat_d = btffa_pkg::STAT_NOMEM;
        end
        if (iss_idx_q < lim) begin
          mem_re     = 1'b1;
          mem_raddr  = iss_idx_q[IDX_W-1:0];
          chk_vld_d  = 1'b1;
          chk_idx_d  = iss_idx_q;
          chk_addr_d = iss_addr_q;
          iss_idx_d  = iss_idx_q + LIM_W'(1);
          iss_addr_d = iss_addr_q + BB_ADDR;
        end else begin
          chk_vld_d = 1'b0;
        end
      end
      btffa_pkg::S_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = mark_idx_q[IDX_W-1:0];
        mem_wdata[btffa_pkg::ENT_TAKEN] = 1'b1;
        mem_wdata[btffa_pkg::ENT_FIRST] = (mark_bytes_q == '0);
        mem_wdata[btffa_pkg::ENT_NEXT]  = mark_more;
        mark_idx_d   = mark_idx_q + LIM_W'(1);
        mark_bytes_d = mark_add;
      end
      btffa_pkg::S_DIV: begin
        if (div_done) begin
          chk_idx_d = LIM_W'(div_quot);
        end
      end
      btffa_pkg::S_FREE_RD: begin
        mem_re    = 1'b1;
        mem_raddr = chk_idx_q[IDX_W-1:0];
      end
      btffa_pkg::S_CHAIN: begin
        mem_we    = 1'b1;
        mem_waddr = chk_idx_q[IDX_W-1:0];
        if (chain_more) begin
          mem_re    = 1'b1;
          mem_raddr = chk_next[IDX_W-1:0];
          chk_idx_d = chk_next;
        end
      end
      btffa_pkg::S_DONE: begin
        if (rsp_free) begin
          rsp_vld_d  = 1'b1;
          rsp_addr_d = res_addr_q;
          rsp_stat_d = res_stat_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= btffa_pkg::S_CLEAR;
      clr_idx_q <= '0;
      chk_vld_q <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
      chk_vld_q <= chk_vld_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      biu_q  <= btffa_pkg::BIU_RESET;
    end else if (cfg_we_i) begin
      unique case (btffa_pkg::reg_idx_e'(cfg_idx_i))
        btffa_pkg::REG_BASE_ADDRESS:  base_q <= cfg_data_i[AW-1:0];
        btffa_pkg::REG_BLOCKS_IN_USE: biu_q  <= cfg_data_i[btffa_pkg::BIU_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    size_q       <= size_d;
    iss_idx_q    <= iss_idx_d;
    iss_addr_q   <= iss_addr_d;
    chk_idx_q    <= chk_idx_d;
    chk_addr_q   <= chk_addr_d;
    run_q        <= run_d;
    first_idx_q  <= first_idx_d;
    first_addr_q <= first_addr_d;
    mark_idx_q   <= mark_idx_d;
    mark_bytes_q <= mark_bytes_d;
    res_addr_q   <= res_addr_d;
    res_stat_q   <= res_stat_d;
    rsp_addr_q   <= rsp_addr_d;
    rsp_stat_q   <= rsp_stat_d;
  end

  assign rsp_o.valid         = rsp_vld_q;
  assign rsp_o.alloc_address = rsp_addr_q;
  assign rsp_o.status        = rsp_stat_q;

  a_mark_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == btffa_pkg::S_MARK) |-> (mark_idx_q < lim))
    else $error("run marking beyond heap limit");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> (state_q != btffa_pkg::S_IDLE))
    else $error("request taken without starting work");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == btffa_pkg::S_DIV))
    else $error("divider result outside divide phase");

  a_clear_blocks_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == btffa_pkg::S_CLEAR) |-> (!req_i.ready && mem_we))
    else $error("request window open during clearing pass");

endmodule

>>> bench/btffa_alloc_checker.sv
// Checker of the allocator: watches both channels and the register port, predicts and compares.
module btffa_alloc_checker
  import btffa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS  = 1024,
  parameter int unsigned BLOCK_BYTES = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  btffa_req_if                 req_i,
  btffa_rsp_if                 rsp_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int unsigned          mismatch_count_o,
  output int unsigned          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ADDR_W-1:0] alloc_address;
    status_e           status;
  } grant_t;

  logic [ENTRY_W-1:0] heap_map [MAX_BLOCKS];
  logic [ADDR_W-1:0]  base_q;
  logic [BIU_W-1:0]   biu_q;
  grant_t             grants_q [$];
  int unsigned        mismatches;

  function automatic int unsigned heap_span();
    return (biu_q > MAX_BLOCKS) ? MAX_BLOCKS : int'(biu_q);
  endfunction

  function automatic grant_t allocate(logic [SIZE_W-1:0] size);
    grant_t             g;
    int unsigned        want, span, run, first, i, j;
    bit                 found;
    logic [ENTRY_W-1:0] e;
    g.alloc_address = '0;
    g.status        = STAT_NOMEM;
    want  = size / BLOCK_BYTES;
    if (size % BLOCK_BYTES != 0) want++;
    span  = heap_span();
    run   = 0;
    first = 0;
    found = 1'b0;
    if (want == 0) return g;
    for (i = 0; i < span; i++) begin
      if (heap_map[i][ENT_TAKEN]) begin
        run = 0;
      end else begin
        if (run == 0) first = i;
        run++;
        if (run == want) begin
          found = 1'b1;
          break;
        end
      end
    end
    if (!found) return g;
    for (j = 0; j < want; j++) begin
      e            = '0;
      e[ENT_TAKEN] = 1'b1;
      e[ENT_FIRST] = (j == 0);
      e[ENT_NEXT]  = (j + 1 < want);
      heap_map[(first + j) % MAX_BLOCKS] = e;
    end
    g.alloc_address = base_q + ADDR_W'(first * BLOCK_BYTES);
    g.status        = STAT_OK;
    return g;
  endfunction

  function automatic grant_t release_chain(logic [ADDR_W-1:0] addr);
    grant_t             g;
    logic [ADDR_W-1:0]  blk;
    int unsigned        span, i;
    logic [ENTRY_W-1:0] e;
    g.alloc_address = '0;
    g.status        = STAT_BADADDR;
    span            = heap_span();
    if (addr < base_q) return g;
    blk = (addr - base_q) / BLOCK_BYTES;
    if (blk >= span) return g;
    for (i = blk; i < span; i++) begin
      e           = heap_map[i];
      heap_map[i] = '0;
      if (!e[ENT_NEXT]) break;
    end
    g.status = STAT_OK;
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    grant_t      exp_g;
    int unsigned i;
    if (!rst_ni) begin
      for (i = 0; i < MAX_BLOCKS; i++) heap_map[i] = '0;
      base_q     = '0;
      biu_q      = BIU_RESET;
      mismatches = 0;
      grants_q.delete();
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (grants_q.size() == 0) begin
          $error("unexpected result word: alloc_address %h status %0d",
                 rsp_i.alloc_address, rsp_i.status);
          mismatches++;
        end else begin
          exp_g = grants_q.pop_front();
          if (rsp_i.alloc_address !== exp_g.alloc_address) begin
            $error("alloc_address: expected %h, actual %h",
                   exp_g.alloc_address, rsp_i.alloc_address);
            mismatches++;
          end
          if (rsp_i.status !== exp_g.status) begin
            $error("status: expected %0d, actual %0d", exp_g.status, rsp_i.status);
            mismatches++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        if (req_i.op == OP_FREE) grants_q.push_back(release_chain(req_i.free_address));
        else grants_q.push_back(allocate(req_i.size_bytes));
      end
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_BASE_ADDRESS:  base_q = cfg_data_i;
          REG_BLOCKS_IN_USE: biu_q  = cfg_data_i[BIU_W-1:0];
          default: ;
        endcase
      end
      mismatch_count_o <= mismatches;
      pending_o        <= grants_q.size();
    end
  end

endmodule

>>> bench/block_table_first_fit_allocator_tb.sv
// Top of the allocator testbench: clock, reset, register set-up, request and result traffic.
module block_table_first_fit_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import btffa_pkg::*;

  localparam int unsigned MAX_BLOCKS  = 1024;
  localparam int unsigned BLOCK_BYTES = 4096;
  localparam int unsigned CYCLE_LIMIT = 6_000_000;
  localparam int unsigned DRAIN       = 64;
  localparam int unsigned HOLD_CYCLES = 600;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  int unsigned          mismatch_count;
  int unsigned          pending_words;

  btffa_req_if req_ch ();
  btffa_rsp_if rsp_ch ();

  block_table_first_fit_allocator #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_ch),
    .rsp_o     (rsp_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  btffa_alloc_checker #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (req_ch),
    .rsp_i           (rsp_ch),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_words)
  );

  op_e               sent_ops [$];
  logic [ADDR_W-1:0] live_q [$];
  logic [ADDR_W-1:0] base_now = '0;
  int unsigned       lim_now  = MAX_BLOCKS;
  bit                calm     = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 99) < 75) ? $urandom_range(1, 3) : $urandom_range(8, 50);
  endfunction

  task automatic send_word(input op_e op, input logic [SIZE_W-1:0] size,
                           input logic [ADDR_W-1:0] addr);
    int unsigned gap;
    req_ch.valid        <= 1'b1;
    req_ch.op           <= op;
    req_ch.size_bytes   <= size;
    req_ch.free_address <= addr;
    do @(posedge clk_i); while (!req_ch.ready);
    sent_ops.push_back(op);
    gap = (!calm && $urandom_range(0, 99) < 45) ? gap_len() : 0;
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic alloc_word(input logic [SIZE_W-1:0] size);
    send_word(OP_ALLOC, size, $urandom);
  endtask

  task automatic free_word(input logic [ADDR_W-1:0] addr);
    send_word(OP_FREE, SIZE_W'($urandom), addr);
  endtask

  // drop valid and wait until every result word is back
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic set_heap(input logic [ADDR_W-1:0] base, input logic [CFG_W-1:0] biu_word);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_BASE_ADDRESS;
    cfg_data_i <= base;
    @(posedge clk_i);
    cfg_idx_i  <= REG_BLOCKS_IN_USE;
    cfg_data_i <= biu_word;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    base_now = base;
    lim_now  = (biu_word[BIU_W-1:0] > MAX_BLOCKS) ? MAX_BLOCKS : biu_word[BIU_W-1:0];
    live_q.delete();
  endtask

  task automatic random_items(input int unsigned count);
    int unsigned       pick, blocks, idx;
    logic [ADDR_W-1:0] a;
    logic [SIZE_W-1:0] s;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        pick = $urandom_range(0, 99);
        if (pick < 70 || lim_now == 0) blocks = $urandom_range(1, 4);
        else blocks = $urandom_range(1, lim_now);
        s = SIZE_W'((blocks - 1) * BLOCK_BYTES + $urandom_range(1, BLOCK_BYTES));
        if (pick >= 85 && pick < 92) s = SIZE_W'($urandom);
        else if (pick >= 92 && pick < 96) s = '0;
        else if (pick >= 96) s = SIZE_W'(blocks * BLOCK_BYTES);
        alloc_word(s);
      end else if (pick < 85 && live_q.size() != 0) begin
        idx = $urandom_range(0, live_q.size() - 1);
        a   = live_q[idx];
        live_q.delete(idx);
        if ($urandom_range(0, 4) == 0) a = a + $urandom_range(1, 2 * BLOCK_BYTES);
        free_word(a);
      end else if (pick < 93) begin
        blocks = (lim_now == 0) ? 0 : $urandom_range(0, lim_now - 1);
        a = base_now + ADDR_W'(blocks * BLOCK_BYTES + $urandom_range(0, BLOCK_BYTES - 1));
        free_word(a);
      end else begin
        free_word($urandom);
      end
    end
  endtask

  // result side: learn granted addresses, stall at random, hold off twice for long
  initial begin : result_side
    int unsigned quiet_left, words_in, next_hold;
    op_e         op;
    rsp_ch.ready = 1'b0;
    quiet_left   = 0;
    words_in     = 0;
    next_hold    = 150;
    forever begin
      @(posedge clk_i);
      if (rsp_ch.valid && rsp_ch.ready) begin
        words_in++;
        if (sent_ops.size() != 0) begin
          op = sent_ops.pop_front();
          if (op == OP_ALLOC && rsp_ch.status == STAT_OK) live_q.push_back(rsp_ch.alloc_address);
        end
      end
      if (quiet_left == 0) begin
        if (words_in >= next_hold) begin
          quiet_left = HOLD_CYCLES;
          next_hold += 300;
        end else if (!calm && $urandom_range(0, 99) < 25) begin
          quiet_left = gap_len();
        end
      end
      if (quiet_left != 0) begin
        rsp_ch.ready <= 1'b0;
        quiet_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned k;
    rst_ni              = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.op           = OP_ALLOC;
    req_ch.size_bytes   = '0;
    req_ch.free_address = '0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = REG_BASE_ADDRESS;
    cfg_data_i          = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    alloc_word(24'd0);
    alloc_word(24'd1);
    alloc_word(24'd4096);
    alloc_word(24'd4097);
    alloc_word(24'hFF_FFFF);
    free_word(32'h0000_3800);
    free_word(32'h0000_2000);
    free_word(32'h0040_0000);
    free_word(32'hFFFF_FFFF);
    alloc_word(24'h3F_F000);
    alloc_word(24'h3F_E000);
    alloc_word(24'd1);
    free_word(32'h0000_1000);
    alloc_word(24'd4096);
    free_word(32'h0000_2FFF);
    free_word(32'h0000_0000);
    free_word(32'h0000_1000);
    alloc_word(24'h40_0000);
    free_word(32'h0000_5000);
    alloc_word(24'h00_3000);
    free_word(32'h0000_0000);
    free_word(32'h0000_1000);
    settle();

    calm = 1'b0;
    set_heap({20'($urandom_range(0, 32'hF_FFFF)), 12'h000}, 32'd1);
    random_items(20);
    settle();
    set_heap(32'hFFFF_FFFF, 32'd0);
    random_items(12);
    settle();
    set_heap(32'hFFFF_C000, 32'd16);
    random_items(60);
    settle();
    set_heap($urandom, 32'd40);
    random_items(70);
    settle();
    calm = 1'b1;
    set_heap({20'($urandom_range(0, 32'hF_FFFF)), 12'h000}, $urandom | 32'h0000_07FF);
    random_items(25);
    settle();

    for (k = 0; k < 6; k++) begin
      calm = ($urandom_range(0, 3) == 0);
      set_heap((k == 0) ? '0 : {20'($urandom_range(0, 32'hF_FFFF)), 12'h000},
               ($urandom & 32'hFFFF_F800) | $urandom_range(2, 96));
      random_items(62);
      settle();
    end

    repeat (DRAIN) @(posedge clk_i);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> block_table_first_fit_allocator.f
rtl/btffa_pkg.sv
rtl/btffa_if.sv
rtl/btffa_mem.sv
rtl/btffa_div.sv
rtl/block_table_first_fit_allocator.sv
bench/btffa_alloc_checker.sv
bench/block_table_first_fit_allocator_tb.sv
